>>> rtl/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache simulator.
package salru_pkg;

    localparam int KIND_W     = 2;
    localparam int IN_ADDR_W  = 64;
    localparam int TAG_W      = 62;
    localparam int RANK_W     = 3;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSTR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_STORE  = 2'd2,
        KIND_MODIFY = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // One cache line as held in a set row of the line memory.
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } t_line;

    // Status of the way scan, meaningful when done is high.
    typedef struct packed {
        logic done;
        logic hit;
        logic free_found;
    } t_scan_stat;

endpackage

>>> rtl/salru_if.sv
// Handshake channel interfaces for the cache simulator: trace input, results and configuration.
interface salru_in_if;
    import salru_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [IN_ADDR_W-1:0] address;
    modport source (output valid, kind, address, input ready);
    modport sink   (input valid, kind, address, output ready);
endinterface

interface salru_out_if;
    import salru_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] evict_count;
    modport source (output valid, hit, evicted, last, hit_count, miss_count, evict_count,
                    input ready);
    modport sink   (input valid, hit, evicted, last, hit_count, miss_count, evict_count,
                    output ready);
endinterface

interface salru_cfg_if;
    import salru_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/salru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/salru_scan.sv
// Way scan: one tag comparator and one rank comparator stepped over the ways of a set.
module salru_scan #(
    parameter int MAX_WAYS = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  salru_pkg::t_line [MAX_WAYS-1:0]            i_row,
    input  logic [salru_pkg::TAG_W-1:0]                i_tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]              i_nways,
    output salru_pkg::t_scan_stat                      o_stat,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] o_hit_way,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] o_free_way,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] o_vic_way
);
    import salru_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);

    logic              r_busy;
    logic              r_done;
    logic [WAY_W-1:0]  r_way;
    logic              r_hit;
    logic [WAY_W-1:0]  r_hit_way;
    logic              r_free;
    logic [WAY_W-1:0]  r_free_way;
    logic [WAY_W-1:0]  r_vic_way;
    logic [RANK_W-1:0] r_vic_rank;
    t_line             cur;

    assign cur = i_row[r_way];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_way      <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_vic_way  <= '0;
                r_vic_rank <= '0;
            end else if (r_busy) begin
                // The first matching way wins, as does the first free way.
                if (!r_hit && cur.valid && cur.tag == i_tag) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= r_way;
                end
                if (!r_free && !cur.valid) begin
                    r_free     <= 1'b1;
                    r_free_way <= r_way;
                end
                // Strictly greater keeps the lowest way among equal oldest ranks.
                if (cur.rank > r_vic_rank) begin
                    r_vic_rank <= cur.rank;
                    r_vic_way  <= r_way;
                end
                if (NW_W'(r_way) + NW_W'(1) == i_nways) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_way <= r_way + WAY_W'(1);
                end
            end
        end
    end

    assign o_stat.done       = r_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.free_found = r_free;
    assign o_hit_way         = r_hit_way;
    assign o_free_way        = r_free_way;
    assign o_vic_way         = r_vic_way;
endmodule

>>> rtl/set_assoc_cache_lru_sim_core.sv
// Top level of the set-associative cache simulator with true LRU replacement.
// A load or store gives one result; a modify looks up the same set and tag twice and gives
// two results, the second marked last; an instruction fetch is taken and gives no result.
// The next item is taken once the last result of the previous item is registered, which
// waits while an earlier result is still held for the sink.
// After reset a clearing pass writes zero to all 2**MAX_SET_BITS set rows before items are taken.
module set_assoc_cache_lru_sim_core #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    salru_in_if.sink    i_in,
    salru_out_if.source o_out,
    salru_cfg_if.sink   i_cfg
);
    import salru_pkg::*;

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int LINE_W = $bits(t_line);
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SHIFT, ST_SPLIT, ST_READ, ST_LOAD, ST_SCAN, ST_UPDATE
    } t_state;

    t_state                  r_state;
    logic [MAX_SET_BITS-1:0] r_clr;
    logic [3:0]              r_set_bits;
    logic [5:0]              r_block_bits;
    logic [3:0]              r_ways;
    t_kind                   r_kind;
    logic                    r_second;
    logic [ADDR_WIDTH-1:0]   r_addr;
    logic [MAX_SET_BITS-1:0] r_set;
    logic [TAG_W-1:0]        r_tag;
    logic [NW_W-1:0]         r_nways;
    logic [CNT_W-1:0]        r_hits;
    logic [CNT_W-1:0]        r_misses;
    logic [CNT_W-1:0]        r_evicts;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic                    r_out_evicted;
    logic                    r_out_last;

    logic [MAX_SET_BITS-1:0] n_set;
    logic [TAG_W-1:0]        n_tag;
    logic [NW_W-1:0]         n_nways;
    t_line [MAX_WAYS-1:0]    n_row;
    logic [CNT_W-1:0]        n_hits;
    logic [CNT_W-1:0]        n_misses;
    logic [CNT_W-1:0]        n_evicts;

    logic [4:0]              sb;
    logic [4:0]              ways_ext;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [ADDR_WIDTH-1:0]   tag_sh;
    logic [ROW_W-1:0]        ram_rdata;
    logic [ROW_W-1:0]        ram_wdata;
    logic [MAX_SET_BITS-1:0] ram_waddr;
    logic                    ram_we;
    t_line [MAX_WAYS-1:0]    rd_row;
    t_scan_stat              stat;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        free_way;
    logic [WAY_W-1:0]        vic_way;
    logic [WAY_W-1:0]        pick;
    logic [RANK_W:0]         limit;
    logic                    evict;
    logic                    commit;
    logic                    in_take;

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == ST_READ),
        .i_raddr (r_set),
        .o_rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    salru_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_LOAD),
        .i_row      (rd_row),
        .i_tag      (r_tag),
        .i_nways    (r_nways),
        .o_stat     (stat),
        .o_hit_way  (hit_way),
        .o_free_way (free_way),
        .o_vic_way  (vic_way)
    );

    // Set index and tag from the address already shifted down by the block bits.
    always_comb begin
        sb       = ({1'b0, r_set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                            : {1'b0, r_set_bits};
        ways_ext = {1'b0, r_ways};
        for (int i = 0; i < MAX_SET_BITS; i++) begin
            set_mask[i] = (5'(i) < sb);
        end
        n_set  = r_addr[MAX_SET_BITS-1:0] & set_mask;
        tag_sh = r_addr >> sb;
        n_tag  = TAG_W'(tag_sh);
        if (ways_ext == 5'd0) begin
            n_nways = NW_W'(1);
        end else if (ways_ext > 5'(MAX_WAYS)) begin
            n_nways = NW_W'(MAX_WAYS);
        end else begin
            n_nways = NW_W'(ways_ext);
        end
    end

    // Row rewrite: the chosen way becomes most recent and younger lines age by one.
    always_comb begin
        evict = !stat.hit && !stat.free_found;
        if (stat.hit) begin
            pick  = hit_way;
            limit = {1'b0, rd_row[hit_way].rank};
        end else if (stat.free_found) begin
            pick  = free_way;
            limit = {1'b1, {RANK_W{1'b0}}};
        end else begin
            pick  = vic_way;
            limit = {1'b0, rd_row[vic_way].rank};
        end
        n_row = rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (NW_W'(w) < r_nways && WAY_W'(w) != pick && rd_row[w].valid
                    && {1'b0, rd_row[w].rank} < limit && rd_row[w].rank != RANK_MAX) begin
                n_row[w].rank = rd_row[w].rank + RANK_W'(1);
            end
        end
        n_row[pick].rank = '0;
        if (!stat.hit) begin
            n_row[pick].valid = 1'b1;
            n_row[pick].tag   = r_tag;
        end
        n_hits   = (stat.hit && r_hits != '1) ? r_hits + CNT_W'(1) : r_hits;
        n_misses = (!stat.hit && r_misses != '1) ? r_misses + CNT_W'(1) : r_misses;
        n_evicts = (evict && r_evicts != '1) ? r_evicts + CNT_W'(1) : r_evicts;
    end

    assign commit    = (r_state == ST_UPDATE) && (!r_out_valid || o_out.ready);
    assign in_take   = i_in.valid && (r_state == ST_IDLE);
    assign ram_we    = (r_state == ST_CLEAR) || commit;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_set;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_set_bits   <= 4'd4;
            r_block_bits <= 6'd4;
            r_ways       <= 4'd1;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_out_valid  <= 1'b0;
            r_second     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg.data[3:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg.data;
                    CFG_WAYS:       r_ways       <= i_cfg.data[3:0];
                    default:        ;
                endcase
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + MAX_SET_BITS'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_take && t_kind'(i_in.kind) != KIND_INSTR) begin
                        r_kind   <= t_kind'(i_in.kind);
                        r_addr   <= i_in.address[ADDR_WIDTH-1:0];
                        r_second <= 1'b0;
                        r_state  <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_addr  <= r_addr >> r_block_bits;
                    r_state <= ST_SPLIT;
                end
                ST_SPLIT: begin
                    r_set   <= n_set;
                    r_tag   <= n_tag;
                    r_nways <= n_nways;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (stat.done) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (commit) begin
                        r_out_valid   <= 1'b1;
                        r_out_hit     <= stat.hit;
                        r_out_evicted <= evict;
                        r_out_last    <= (r_kind != KIND_MODIFY) || r_second;
                        r_hits        <= n_hits;
                        r_misses      <= n_misses;
                        r_evicts      <= n_evicts;
                        if (r_kind == KIND_MODIFY && !r_second) begin
                            // A modify looks up the same set and tag a second time.
                            r_second <= 1'b1;
                            r_state  <= ST_READ;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_out_hit;
    assign o_out.evicted     = r_out_evicted;
    assign o_out.last        = r_out_last;
    assign o_out.hit_count   = r_hits;
    assign o_out.miss_count  = r_misses;
    assign o_out.evict_count = r_evicts;

`ifndef SYNTH
    a_not_last_is_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_kind == KIND_MODIFY))
        else $error("non-final result for an item that is not a modify");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!r_out_valid && !i_in.ready))
        else $error("traffic during the clearing pass");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> (r_state == ST_SCAN))
        else $error("way scan finished outside the scan state");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evicted))
        else $error("result reports both hit and eviction");

    a_counts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hits >= $past(r_hits) && r_misses >= $past(r_misses)
                            && r_evicts >= $past(r_evicts)))
        else $error("running total went down");
`endif
endmodule

>>> bench/tb_top.sv
// Self-checking bench for the set-associative LRU cache simulator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import salru_pkg::*;

    localparam int MAX_SET_BITS  = 10;
    localparam int MAX_WAYS      = 8;
    localparam int LINES         = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int PHASE_LOOKUPS = 115;
    localparam int SETTLE_CYCLES = 24;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_kind                kind;
        logic [IN_ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic             last;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_lookup;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    salru_in_if  in_bus();
    salru_out_if out_bus();
    salru_cfg_if cfg_bus();

    logic                  drv_valid = 1'b0;
    t_kind                 drv_kind  = KIND_INSTR;
    logic [IN_ADDR_W-1:0]  drv_addr  = '0;
    logic                  rsp_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    assign in_bus.valid    = drv_valid;
    assign in_bus.kind     = drv_kind;
    assign in_bus.address  = drv_addr;
    assign out_bus.ready   = rsp_ready;
    assign cfg_bus.valid   = cfg_valid;
    assign cfg_bus.index   = cfg_index;
    assign cfg_bus.data    = cfg_data;

    set_assoc_cache_lru_sim_core #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .ADDR_WIDTH  (IN_ADDR_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the line memory, the totals and the registers.
    bit [TAG_W-1:0]  shadow_tag   [LINES];
    bit              shadow_valid [LINES];
    bit [RANK_W-1:0] shadow_rank  [LINES];
    bit [CNT_W-1:0]  hits_total;
    bit [CNT_W-1:0]  misses_total;
    bit [CNT_W-1:0]  evictions_total;
    bit [3:0]        set_bits_reg   = 4'd4;
    bit [5:0]        block_bits_reg = 6'd4;
    bit [3:0]        ways_reg       = 4'd1;

    t_access        trace_queue[$];
    t_lookup        pending_lookups[$];
    logic [63:0]    pool_tag[$];
    int             pool_set[$];
    int             trace_gap    = 0;
    int             result_stall = 0;
    bit             trace_burst  = 1'b0;
    bit             result_burst = 1'b0;
    int             mismatches   = 0;
    int             gen_sb;
    int             gen_bb;
    int             gen_nw;

    function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void age_ranks(int base, int nw, int limit, int skip);
        for (int w = 0; w < nw; w++) begin
            if (w != skip && shadow_valid[base+w] && int'(shadow_rank[base+w]) < limit &&
                shadow_rank[base+w] < RANK_MAX)
                shadow_rank[base+w] = shadow_rank[base+w] + 1'b1;
        end
    endfunction

    function automatic t_lookup cache_lookup(logic [IN_ADDR_W-1:0] addr);
        int                   sb;
        int                   bb;
        int                   nw;
        int                   base;
        int                   pick;
        logic [IN_ADDR_W-1:0] set_idx;
        bit [TAG_W-1:0]       tag;
        bit                   found_free;
        t_lookup              res;
        sb = (int'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
        bb = int'(block_bits_reg);
        nw = (ways_reg == 0) ? 1 : ((int'(ways_reg) > MAX_WAYS) ? MAX_WAYS : int'(ways_reg));
        set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        tag = (sb + bb >= 64) ? '0 : TAG_W'(addr >> (sb + bb));
        base = int'(set_idx) * MAX_WAYS;
        res = '0;
        found_free = 1'b0;
        pick = 0;
        for (int w = 0; w < nw; w++) begin
            if (!res.hit && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
                age_ranks(base, nw, int'(shadow_rank[base+w]), w);
                shadow_rank[base+w] = '0;
                hits_total = sat_inc(hits_total);
                res.hit = 1'b1;
            end
        end
        if (!res.hit) begin
            misses_total = sat_inc(misses_total);
            for (int w = 0; w < nw; w++) begin
                if (!found_free && !shadow_valid[base+w]) begin
                    pick = w;
                    found_free = 1'b1;
                end
            end
            if (found_free) begin
                age_ranks(base, nw, int'(RANK_MAX) + 1, pick);
            end else begin
                // Oldest line goes; the lowest way wins a tie.
                for (int w = 1; w < nw; w++) begin
                    if (shadow_rank[base+w] > shadow_rank[base+pick])
                        pick = w;
                end
                age_ranks(base, nw, int'(shadow_rank[base+pick]), pick);
                evictions_total = sat_inc(evictions_total);
                res.evicted = 1'b1;
            end
            shadow_tag[base+pick]   = tag;
            shadow_valid[base+pick] = 1'b1;
            shadow_rank[base+pick]  = '0;
        end
        res.hits      = hits_total;
        res.misses    = misses_total;
        res.evictions = evictions_total;
        return res;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Trace driver; it also updates the shadow state on every accepted load, store or modify and every write.
    always @(posedge i_clk) begin
        t_access acc;
        t_lookup res;
        bit      busy;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            trace_gap <= 0;
        end else begin
            if (cfg_valid && cfg_bus.ready) begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   = cfg_data[3:0];
                    CFG_BLOCK_BITS: block_bits_reg = cfg_data;
                    CFG_WAYS:       ways_reg       = cfg_data[3:0];
                    default: ;
                endcase
            end
            busy = drv_valid;
            if (drv_valid && in_bus.ready) begin
                busy = 1'b0;
                if (drv_kind != KIND_INSTR) begin
                    res = cache_lookup(drv_addr);
                    if (drv_kind == KIND_MODIFY) begin
                        pending_lookups.push_back(res);
                        res = cache_lookup(drv_addr);
                    end
                    res.last = 1'b1;
                    pending_lookups.push_back(res);
                end
            end
            if (!busy) begin
                if (trace_gap != 0) begin
                    trace_gap <= trace_gap - 1;
                    drv_valid <= 1'b0;
                end else if (trace_queue.size() != 0) begin
                    acc = trace_queue.pop_front();
                    drv_kind  <= acc.kind;
                    drv_addr  <= acc.address;
                    drv_valid <= 1'b1;
                    if ($urandom_range(0, 47) == 0)
                        trace_burst = !trace_burst;
                    trace_gap <= trace_burst ? 0 : int'($urandom_range(0, 11));
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own random back-pressure.
    always @(posedge i_clk) begin
        t_lookup want;
        int      stall;
        if (!i_rst_n) begin
            rsp_ready    <= 1'b0;
            result_stall <= 0;
        end else if (rsp_ready && out_bus.valid) begin
            if (pending_lookups.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, got hit %0b evicted %0b last %0b",
                         $time, out_bus.hit, out_bus.evicted, out_bus.last);
            end else begin
                want = pending_lookups.pop_front();
                check_field("hit", want.hit, out_bus.hit);
                check_field("evicted", want.evicted, out_bus.evicted);
                check_field("last", want.last, out_bus.last);
                check_field("hit_count", want.hits, out_bus.hit_count);
                check_field("miss_count", want.misses, out_bus.miss_count);
                check_field("evict_count", want.evictions, out_bus.evict_count);
            end
            if ($urandom_range(0, 47) == 0)
                result_burst = !result_burst;
            stall = result_burst ? 0 : int'($urandom_range(0, 11));
            rsp_ready    <= (stall == 0);
            result_stall <= stall;
        end else if (result_stall != 0) begin
            rsp_ready    <= (result_stall == 1);
            result_stall <= result_stall - 1;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // The two bits above a four-bit field are random so that their masking is exercised.
    task automatic write_setting(int sb, int bb, int nw);
        write_reg(CFG_SET_BITS, {2'($urandom_range(0, 3)), 4'(sb)});
        write_reg(CFG_BLOCK_BITS, 6'(bb));
        write_reg(CFG_WAYS, {2'($urandom_range(0, 3)), 4'(nw)});
        gen_sb = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
        gen_bb = bb;
        gen_nw = (nw == 0) ? 1 : ((nw > MAX_WAYS) ? MAX_WAYS : nw);
    endtask

    // Sampled on the falling edge so that the driver's updates at the rising edge have settled.
    task automatic drain();
        while (trace_queue.size() != 0 || drv_valid || pending_lookups.size() != 0)
            @(negedge i_clk);
        // An instruction fetch may still be in the block with nothing to wait for.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Most accesses hit a small working set spread over two sets, a little over the
    // ways in use, so that hits, fills and evictions all occur; the rest is noise.
    task automatic run_phase(int lookups_wanted, bit fresh_pool);
        int          sets[2];
        int          done;
        int          k;
        logic [63:0] tag;
        logic [63:0] offset;
        t_access     acc;
        if (fresh_pool) begin
            pool_tag.delete();
            pool_set.delete();
            sets[0] = int'($urandom_range(0, (1 << gen_sb) - 1));
            sets[1] = int'($urandom_range(0, (1 << gen_sb) - 1));
            for (int i = 0; i < 2 * (gen_nw + 2); i++) begin
                // Tags that differ only in the top bits alias when few bits are shifted out.
                if (i > 0 && $urandom_range(0, 3) == 0)
                    tag = pool_tag[i-1] ^ {2'($urandom_range(1, 3)), 62'd0};
                else
                    tag = {$urandom, $urandom};
                pool_tag.push_back(tag);
                pool_set.push_back(sets[i % 2]);
            end
        end
        done = 0;
        while (done < lookups_wanted) begin
            acc.kind = ($urandom_range(0, 9) == 0) ? KIND_INSTR
                                                    : t_kind'(2'($urandom_range(1, 3)));
            if ($urandom_range(0, 6) == 0) begin
                acc.address = {$urandom, $urandom};
            end else begin
                k = int'($urandom_range(0, pool_tag.size() - 1));
                offset = {$urandom, $urandom} & ((64'd1 << gen_bb) - 64'd1);
                acc.address = (pool_tag[k] << (gen_sb + gen_bb)) |
                              ((64'(pool_set[k]) & ((64'd1 << gen_sb) - 64'd1)) << gen_bb) |
                              offset;
            end
            if (acc.kind != KIND_INSTR)
                done++;
            trace_queue.push_back(acc);
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_SPARE, 6'($urandom_range(0, 63)));

        // Directed part: four sets of two ways, 16-byte blocks, so tags start at bit 6.
        write_setting(2, 4, 2);
        trace_queue.push_back('{KIND_LOAD,   64'h0000_0000_0000_0000});
        trace_queue.push_back('{KIND_LOAD,   64'h0000_0000_0000_000F});
        trace_queue.push_back('{KIND_STORE,  64'h0000_0000_0000_0040});
        trace_queue.push_back('{KIND_MODIFY, 64'h0000_0000_0000_0080});
        trace_queue.push_back('{KIND_LOAD,   64'h0000_0000_0000_0000});
        trace_queue.push_back('{KIND_INSTR,  64'hFFFF_FFFF_FFFF_FFFF});
        trace_queue.push_back('{KIND_LOAD,   64'hFFFF_FFFF_FFFF_FFFF});
        trace_queue.push_back('{KIND_STORE,  64'hFFFF_FFFF_FFFF_FFF0});
        trace_queue.push_back('{KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF});
        trace_queue.push_back('{KIND_LOAD,   64'h0000_0000_0000_0080});
        trace_queue.push_back('{KIND_STORE,  64'h0000_0000_0000_00C0});
        trace_queue.push_back('{KIND_LOAD,   64'h8000_0000_0000_0000});
        trace_queue.push_back('{KIND_LOAD,   64'h4000_0000_0000_0030});
        trace_queue.push_back('{KIND_MODIFY, 64'h0000_0000_0000_0010});
        trace_queue.push_back('{KIND_INSTR,  64'h0000_0000_0000_0000});
        trace_queue.push_back('{KIND_STORE,  64'hAAAA_AAAA_AAAA_AAAA});
        trace_queue.push_back('{KIND_LOAD,   64'h5555_5555_5555_5555});
        trace_queue.push_back('{KIND_MODIFY, 64'h0000_0000_0000_0040});
        drain();

        write_setting(1, 1, 1);
        run_phase(PHASE_LOOKUPS, 1'b1);
        write_setting(10, 32, 8);
        run_phase(PHASE_LOOKUPS, 1'b1);
        // Shrink and regrow the ways over the same lines; nothing is flushed.
        write_setting(10, 32, 2);
        run_phase(PHASE_LOOKUPS, 1'b0);
        write_setting(10, 32, 8);
        run_phase(PHASE_LOOKUPS, 1'b0);
        // Zero set bits and zero ways, and no bits shifted out of the tag.
        write_setting(0, 0, 0);
        run_phase(PHASE_LOOKUPS, 1'b1);
        write_setting(15, 63, 15);
        run_phase(PHASE_LOOKUPS, 1'b1);
        write_setting(11, 60, 9);
        run_phase(PHASE_LOOKUPS, 1'b1);
        write_setting(1, 0, 5);
        run_phase(PHASE_LOOKUPS, 1'b1);
        write_setting(4, 4, 1);
        run_phase(PHASE_LOOKUPS, 1'b1);
        repeat (5) begin
            write_setting(int'($urandom_range(1, 10)), int'($urandom_range(1, 32)),
                          int'($urandom_range(1, 8)));
            run_phase(PHASE_LOOKUPS, 1'b1);
        end

        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
